### hw/rtl/conretx_pkg.sv
// Shared types and constants for the confirmable retransmit controller.
`default_nettype none

package conretx_pkg;

    localparam int CFG_DATA_BITS  = 32;
    localparam int REG_INDEX_BITS = 3;
    localparam int ID_WIDTH       = 16;
    localparam int RANDOM_WIDTH   = 16;
    localparam int MIN_BITS       = 32;
    localparam int SPAN_BITS      = 31;
    localparam int RETRY_BITS     = 4;
    localparam int PKT_BITS       = 16;
    localparam int SECOND_BITS    = 32;
    localparam int COUNT_BITS     = 16;
    localparam int RATE_BITS      = 32;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_OTHER = 2'd3
    } cmd_t;

    typedef enum logic [REG_INDEX_BITS-1:0] {
        REG_TIMEOUT_MIN   = 3'd0,
        REG_TIMEOUT_SPAN  = 3'd1,
        REG_RETRY_LIMIT   = 3'd2,
        REG_PKT_LENGTH    = 3'd3,
        REG_TICKS_PER_SEC = 3'd4,
        REG_INITIAL_ID    = 3'd5
    } reg_index_t;

    localparam logic KIND_CON    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [MIN_BITS-1:0]    RST_TIMEOUT_MIN   = 32'd2000;
    localparam logic [SPAN_BITS-1:0]   RST_TIMEOUT_SPAN  = 31'd1000;
    localparam logic [RETRY_BITS-1:0]  RST_RETRY_LIMIT   = 4'd4;
    localparam logic [PKT_BITS-1:0]    RST_PKT_LENGTH    = 16'd1024;
    localparam logic [SECOND_BITS-1:0] RST_TICKS_PER_SEC = 32'd1000;
    localparam logic [ID_WIDTH-1:0]    RST_INITIAL_ID    = 16'd0;

    typedef struct packed {
        logic [MIN_BITS-1:0]    timeout_min;
        logic [SPAN_BITS-1:0]   timeout_span;
        logic [RETRY_BITS-1:0]  retry_limit;
        logic [PKT_BITS-1:0]    pkt_length;
        logic [SECOND_BITS-1:0] ticks_per_second;
        logic [ID_WIDTH-1:0]    initial_id;
    } cfg_t;

    typedef struct packed {
        logic                 kind;
        logic [ID_WIDTH-1:0]  message_id;
        logic                 is_retransmit;
        logic                 previous_failed;
        logic [RATE_BITS-1:0] upload_rate_bits;
        logic                 last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_pair_t;

endpackage

`default_nettype wire

### hw/rtl/conretx_cfg.sv
// Configuration register bank with write-only port.
`default_nettype none

module conretx_cfg
    import conretx_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [REG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                           cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_min      <= RST_TIMEOUT_MIN;
            cfg_reg.timeout_span     <= RST_TIMEOUT_SPAN;
            cfg_reg.retry_limit      <= RST_RETRY_LIMIT;
            cfg_reg.pkt_length       <= RST_PKT_LENGTH;
            cfg_reg.ticks_per_second <= RST_TICKS_PER_SEC;
            cfg_reg.initial_id       <= RST_INITIAL_ID;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TIMEOUT_MIN:   cfg_reg.timeout_min      <= cfg_data[MIN_BITS-1:0];
                REG_TIMEOUT_SPAN:  cfg_reg.timeout_span     <= cfg_data[SPAN_BITS-1:0];
                REG_RETRY_LIMIT:   cfg_reg.retry_limit      <= cfg_data[RETRY_BITS-1:0];
                REG_PKT_LENGTH:    cfg_reg.pkt_length       <= cfg_data[PKT_BITS-1:0];
                REG_TICKS_PER_SEC: cfg_reg.ticks_per_second <= cfg_data[SECOND_BITS-1:0];
                REG_INITIAL_ID:    cfg_reg.initial_id       <= cfg_data[ID_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### hw/rtl/conretx_core.sv
// Input register, retransmit state and per-word result logic.
`default_nettype none

module conretx_core
    import conretx_pkg::*;
#(
    parameter int TIMER_BITS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  cfg_t                         cfg,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              command,
    input  wire logic [ID_WIDTH-1:0]     ack_id,
    input  wire logic [RANDOM_WIDTH-1:0] random_value,
    output logic                         load,
    output res_pair_t                    load_pair,
    input  wire logic                    load_ok
);

    localparam int SUM_BITS  = ((TIMER_BITS > MIN_BITS) ? TIMER_BITS : MIN_BITS) + 1;
    localparam int PROD_BITS = RANDOM_WIDTH + SPAN_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // input stage
    logic                  stg_valid_reg;
    cmd_t                  stg_cmd_reg;
    logic [ID_WIDTH-1:0]   stg_ack_reg;
    logic [SPAN_BITS-1:0]  stg_spread_reg;
    logic [PROD_BITS-1:0]  prod;
    logic                  fire;

    // state
    logic                   running_reg,         running_next;
    logic [ID_WIDTH-1:0]    current_id_reg,      current_id_next;
    logic [TIMER_BITS-1:0]  current_timeout_reg, current_timeout_next;
    logic [TIMER_BITS-1:0]  remaining_ticks_reg, remaining_ticks_next;
    logic [RETRY_BITS-1:0]  retry_count_reg,     retry_count_next;
    logic [COUNT_BITS-1:0]  sent_reg,            sent_next;
    logic [SECOND_BITS-1:0] second_ticks_reg,    second_ticks_next;

    logic [SUM_BITS-1:0]    draw_sum;
    logic [TIMER_BITS-1:0]  draw_to;
    logic [TIMER_BITS-1:0]  dbl_to;
    logic                   expired;
    logic [RETRY_BITS:0]    retry_inc;
    logic                   retry_ok;
    logic [SECOND_BITS-1:0] second_inc;
    logic                   report_due;
    logic                   con;
    logic                   con_retx;
    logic                   con_failed;
    logic                   rpt;
    logic [COUNT_BITS-1:0]  sent_con;
    logic [RATE_BITS-1:0]   rate;
    result_t                con_res;
    result_t                rpt_res;

    assign prod     = PROD_BITS'(random_value) * PROD_BITS'(cfg.timeout_span);
    assign fire     = stg_valid_reg && load_ok;
    assign in_ready = !stg_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stg_cmd_reg    <= cmd_t'(command);
            stg_ack_reg    <= ack_id;
            stg_spread_reg <= prod[PROD_BITS-1:RANDOM_WIDTH];
        end
    end

    assign draw_sum   = SUM_BITS'(cfg.timeout_min) + SUM_BITS'(stg_spread_reg);
    assign draw_to    = (draw_sum > SUM_BITS'(TIMER_MAX)) ? TIMER_MAX
                                                          : draw_sum[TIMER_BITS-1:0];
    assign dbl_to     = current_timeout_reg[TIMER_BITS-1]
                        ? TIMER_MAX
                        : {current_timeout_reg[TIMER_BITS-2:0], 1'b0};
    assign expired    = remaining_ticks_reg <= TIMER_BITS'(1);
    assign retry_inc  = {1'b0, retry_count_reg} + (RETRY_BITS+1)'(1);
    assign retry_ok   = retry_inc <= {1'b0, cfg.retry_limit};
    assign second_inc = second_ticks_reg + SECOND_BITS'(1);
    assign report_due = second_inc >= cfg.ticks_per_second;

    always_comb
    begin
        running_next         = running_reg;
        current_id_next      = current_id_reg;
        current_timeout_next = current_timeout_reg;
        remaining_ticks_next = remaining_ticks_reg;
        retry_count_next     = retry_count_reg;
        second_ticks_next    = second_ticks_reg;
        con                  = 1'b0;
        con_retx             = 1'b0;
        con_failed           = 1'b0;
        rpt                  = 1'b0;
        unique case (stg_cmd_reg)
            CMD_START:
            begin
                if (!running_reg)
                begin
                    running_next         = 1'b1;
                    current_id_next      = cfg.initial_id;
                    retry_count_next     = '0;
                    current_timeout_next = draw_to;
                    remaining_ticks_next = draw_to;
                    con                  = 1'b1;
                end
            end
            CMD_TICK:
            begin
                if (running_reg)
                begin
                    if (expired)
                    begin
                        con = 1'b1;
                        if (retry_ok)
                        begin
                            retry_count_next     = retry_inc[RETRY_BITS-1:0];
                            current_timeout_next = dbl_to;
                            remaining_ticks_next = dbl_to;
                            con_retx             = 1'b1;
                        end
                        else
                        begin
                            current_id_next      = current_id_reg + ID_WIDTH'(1);
                            retry_count_next     = '0;
                            current_timeout_next = draw_to;
                            remaining_ticks_next = draw_to;
                            con_failed           = 1'b1;
                        end
                    end
                    else
                    begin
                        remaining_ticks_next = remaining_ticks_reg - TIMER_BITS'(1);
                    end
                end
                second_ticks_next = second_inc;
                if (report_due)
                begin
                    second_ticks_next = '0;
                    rpt               = 1'b1;
                end
            end
            CMD_ACK:
            begin
                if (running_reg)
                begin
                    con = 1'b1;
                    if (stg_ack_reg == current_id_reg)
                    begin
                        current_id_next      = current_id_reg + ID_WIDTH'(1);
                        retry_count_next     = '0;
                        current_timeout_next = draw_to;
                        remaining_ticks_next = draw_to;
                    end
                    else
                    begin
                        current_timeout_next = dbl_to;
                        remaining_ticks_next = dbl_to;
                        con_retx             = 1'b1;
                    end
                end
            end
            CMD_OTHER: ;
            default:   ;
        endcase
    end

    // packet counter saturates; report reads the count including this word's packet
    assign sent_con  = (con && sent_reg != COUNT_MAX) ? sent_reg + COUNT_BITS'(1) : sent_reg;
    assign rate      = RATE_BITS'(cfg.pkt_length) * RATE_BITS'(sent_con);
    assign sent_next = rpt ? '0 : sent_con;

    always_comb
    begin
        con_res.kind             = KIND_CON;
        con_res.message_id       = current_id_next;
        con_res.is_retransmit    = con_retx;
        con_res.previous_failed  = con_failed;
        con_res.upload_rate_bits = '0;
        con_res.last             = !rpt;

        rpt_res.kind             = KIND_REPORT;
        rpt_res.message_id       = '0;
        rpt_res.is_retransmit    = 1'b0;
        rpt_res.previous_failed  = 1'b0;
        rpt_res.upload_rate_bits = rate;
        rpt_res.last             = 1'b1;

        load_pair.count  = 2'(con) + 2'(rpt);
        load_pair.first  = con ? con_res : rpt_res;
        load_pair.second = rpt_res;
    end

    assign load = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg         <= 1'b0;
            current_id_reg      <= RST_INITIAL_ID;
            current_timeout_reg <= '0;
            remaining_ticks_reg <= '0;
            retry_count_reg     <= '0;
            sent_reg            <= '0;
            second_ticks_reg    <= '0;
        end
        else if (fire)
        begin
            running_reg         <= running_next;
            current_id_reg      <= current_id_next;
            current_timeout_reg <= current_timeout_next;
            remaining_ticks_reg <= remaining_ticks_next;
            retry_count_reg     <= retry_count_next;
            sent_reg            <= sent_next;
            second_ticks_reg    <= second_ticks_next;
        end
    end

    a_remaining_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_ticks_reg <= current_timeout_reg)
        else $error("remaining ticks above armed timeout");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (retry_count_reg == '0 && remaining_ticks_reg == '0))
        else $error("retry state set before start");

    a_start_loads_id: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stg_cmd_reg == CMD_START && !running_reg)
        |=> (running_reg && current_id_reg == $past(cfg.initial_id)))
        else $error("start did not load initial ID");

endmodule

`default_nettype wire

### hw/rtl/conretx_obuf.sv
// Output buffer holding up to two result words and draining them in order.
`default_nettype none

module conretx_obuf
    import conretx_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  res_pair_t                 load_pair,
    output logic                      load_ok,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      kind,
    output logic [ID_WIDTH-1:0]       message_id,
    output logic                      is_retransmit,
    output logic                      previous_failed,
    output logic [RATE_BITS-1:0]      upload_rate_bits,
    output logic                      last
);

    logic [1:0] cnt_reg;
    result_t    first_reg;
    result_t    second_reg;
    logic       take;

    assign out_valid = cnt_reg != 2'd0;
    assign take      = out_valid && out_ready;
    assign load_ok   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= load_pair.count;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg  <= load_pair.first;
            second_reg <= load_pair.second;
        end
        else if (take && cnt_reg == 2'd2)
        begin
            first_reg <= second_reg;
        end
    end

    assign kind             = first_reg.kind;
    assign message_id       = first_reg.message_id;
    assign is_retransmit    = first_reg.is_retransmit;
    assign previous_failed  = first_reg.previous_failed;
    assign upload_rate_bits = first_reg.upload_rate_bits;
    assign last             = first_reg.last;

endmodule

`default_nettype wire

### hw/rtl/confirmable_retransmit_controller_top.sv
// Top level of the confirmable retransmit controller.
// Sender-side retransmit controller with exponential back-off and a once-per-second
// rate report. An accepted word is held in the input register and is evaluated when
// the output buffer can take its results, which then enter the output buffer; the first
// result is offered from the output buffer register. One word is accepted per
// cycle while each word yields at most one result and the receiver keeps up. A tick
// that both sends a packet and issues a report yields two results and fills the
// two-entry output buffer, so the next word waits until one of them has drained.
// Throughput is set by the output buffer draining one result per cycle while the
// receiver is ready. Write configuration only while no words are in flight.
`default_nettype none

module confirmable_retransmit_controller_top
    import conretx_pkg::*;
#(
    parameter int TIMER_BITS = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [REG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                command,
    input  wire logic [ID_WIDTH-1:0]       ack_id,
    input  wire logic [RANDOM_WIDTH-1:0]   random_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           kind,
    output logic [ID_WIDTH-1:0]            message_id,
    output logic                           is_retransmit,
    output logic                           previous_failed,
    output logic [RATE_BITS-1:0]           upload_rate_bits,
    output logic                           last
);

    cfg_t      cfg;
    logic      load;
    res_pair_t load_pair;
    logic      load_ok;

    conretx_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    conretx_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .ack_id       (ack_id),
        .random_value (random_value),
        .load         (load),
        .load_pair    (load_pair),
        .load_ok      (load_ok)
    );

    conretx_obuf u_obuf (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (load),
        .load_pair        (load_pair),
        .load_ok          (load_ok),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .message_id       (message_id),
        .is_retransmit    (is_retransmit),
        .previous_failed  (previous_failed),
        .upload_rate_bits (upload_rate_bits),
        .last             (last)
    );

endmodule

`default_nettype wire
